[rtl/aip_pkg.sv]
package aip_pkg;

  localparam int CODE_W  = 21;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 7;
  localparam int DIGIT_W = 6;

  localparam int MAX_VALUE_BITS = 64;
  localparam int LENGTH_MARGIN  = 10;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

  localparam logic [CODE_W-1:0] CHAR_PLUS    = 21'h2B;
  localparam logic [CODE_W-1:0] CHAR_MINUS   = 21'h2D;
  localparam logic [CODE_W-1:0] CHAR_DIGIT_0 = 21'h30;
  localparam logic [CODE_W-1:0] CHAR_DIGIT_9 = 21'h39;
  localparam logic [CODE_W-1:0] CHAR_UPPER_A = 21'h41;
  localparam logic [CODE_W-1:0] CHAR_UPPER_X = 21'h58;
  localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 21'h5A;
  localparam logic [CODE_W-1:0] CHAR_LOWER_A = 21'h61;
  localparam logic [CODE_W-1:0] CHAR_LOWER_X = 21'h78;
  localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 21'h7A;

  localparam logic [1:0] CFG_NUMBER_BASE     = 2'd0;
  localparam logic [1:0] CFG_VALUE_SIZE_CODE = 2'd1;
  localparam logic [1:0] CFG_IS_SIGNED_TYPE  = 2'd2;
  localparam logic [1:0] CFG_DEFAULT_VALUE   = 2'd3;

  localparam logic [DIGIT_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [DIGIT_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [DIGIT_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_AUTO = 6'd0;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_AFTER_X,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               last;
    logic [DIGIT_W-1:0] digit;
    logic               is_sign;
    logic               is_minus;
    logic               is_x;
  } char_item_t;

  typedef struct packed {
    logic [5:0]         number_base;
    logic [1:0]         value_size_code;
    logic               is_signed_type;
    logic [VALUE_W-1:0] default_value;
  } cfg_t;

  function automatic logic [COUNT_W-1:0] type_bits(input logic [1:0] size_code);
    logic [7:0] b;
    b = 8'd8 << size_code;
    for (int i = 0; i < 3; i++) begin
      if (int'(b) > MAX_VALUE_BITS && b > 8'd8) begin
        b = b >> 1;
      end
    end
    return b[COUNT_W-1:0];
  endfunction

endpackage

[rtl/aip_front.sv]
module aip_front (
  input  logic                      tvalid,
  output logic                      tready,
  input  logic [aip_pkg::CODE_W-1:0] code_unit,
  input  logic                      tlast,
  input  logic                      full,
  output logic                      push,
  output aip_pkg::char_item_t       item
);
  import aip_pkg::*;

  assign tready = !full;
  assign push   = tvalid;

  always_comb begin
    item.last     = tlast;
    item.is_sign  = (code_unit == CHAR_PLUS) || (code_unit == CHAR_MINUS);
    item.is_minus = (code_unit == CHAR_MINUS);
    item.is_x     = (code_unit == CHAR_LOWER_X) || (code_unit == CHAR_UPPER_X);
    if (code_unit inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
      item.digit = DIGIT_W'(code_unit - CHAR_DIGIT_0);
    end else if (code_unit inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      item.digit = DIGIT_W'(code_unit - CHAR_LOWER_A) + RADIX_DEC;
    end else if (code_unit inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      item.digit = DIGIT_W'(code_unit - CHAR_UPPER_A) + RADIX_DEC;
    end else begin
      item.digit = DIGIT_NONE;
    end
  end

endmodule

[rtl/aip_queue.sv]
module aip_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  aip_pkg::char_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output aip_pkg::char_item_t head
);
  import aip_pkg::*;

  char_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/aip_back.sv]
module aip_back (
  input  logic                        clk,
  input  logic                        rst,
  input  aip_pkg::cfg_t               cfg,
  input  logic                        empty,
  input  aip_pkg::char_item_t         head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [aip_pkg::VALUE_W-1:0] number_value,
  output logic                        parse_ok,
  output logic [aip_pkg::COUNT_W-1:0] consumed_count
);
  import aip_pkg::*;

  logic [VALUE_W-1:0] acc, acc_next;
  logic               overflow, overflow_next;
  logic               neg, neg_next;
  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] taken, taken_next;
  logic [COUNT_W-1:0] accepted, accepted_next;
  logic [DIGIT_W-1:0] radix, radix_next;

  logic               base_ok;
  logic [COUNT_W-1:0] tbits;
  logic [COUNT_W-1:0] taken_inc;
  logic [DIGIT_W-1:0] radix_sel;
  logic               use_digit;
  logic [VALUE_W+6:0] mac;
  logic               out_free;
  logic               char_pop;
  logic               end_pop;
  logic               res_ok;
  logic [VALUE_W-1:0] signed_val;
  logic [VALUE_W-1:0] half;
  logic [VALUE_W-1:0] lim;

  assign base_ok   = (cfg.number_base == RADIX_AUTO) ||
                     (cfg.number_base >= 6'd2 && cfg.number_base <= RADIX_MAX);
  assign tbits     = type_bits(cfg.value_size_code);
  assign taken_inc = taken + 7'd1;
  assign out_free  = !out_valid || out_ready;
  assign pop       = !empty && (!head.last || out_free);
  assign char_pop  = pop && !head.last;
  assign end_pop   = pop && head.last;
  assign mac       = (71'(acc) * 71'(radix_sel)) + 71'(head.digit);

  always_comb begin
    acc_next      = acc;
    overflow_next = overflow;
    neg_next      = neg;
    phase_next    = phase;
    taken_next    = taken;
    accepted_next = accepted;
    radix_next    = radix;
    radix_sel     = radix;
    use_digit     = 1'b0;
    if (end_pop) begin
      acc_next      = '0;
      overflow_next = 1'b0;
      neg_next      = 1'b0;
      phase_next    = PH_START;
      taken_next    = '0;
      accepted_next = '0;
      radix_next    = RADIX_DEC;
    end else if (char_pop && phase != PH_DONE) begin
      if (!base_ok || taken >= tbits + COUNT_W'(LENGTH_MARGIN)) begin
        phase_next = PH_DONE;
      end else begin
        taken_next = taken_inc;
        case (phase)
          PH_START, PH_SIGNED: begin
            if (phase == PH_START && head.is_sign) begin
              neg_next   = head.is_minus;
              phase_next = PH_SIGNED;
            end else if ((cfg.number_base == RADIX_AUTO || cfg.number_base == RADIX_HEX) &&
                         head.digit == '0) begin
              acc_next      = '0;
              phase_next    = PH_ZERO;
              accepted_next = taken_inc;
            end else begin
              radix_sel = (cfg.number_base == RADIX_AUTO) ? RADIX_DEC : cfg.number_base;
              use_digit = 1'b1;
            end
          end
          PH_ZERO: begin
            if (head.is_x) begin
              phase_next = PH_AFTER_X;
            end else begin
              radix_sel = (cfg.number_base == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
              use_digit = 1'b1;
            end
          end
          PH_AFTER_X: begin
            radix_sel = RADIX_HEX;
            use_digit = 1'b1;
          end
          default: begin
            use_digit = 1'b1;
          end
        endcase
        if (use_digit) begin
          radix_next = radix_sel;
          if (head.digit < radix_sel) begin
            if (|mac[VALUE_W+6:VALUE_W]) begin
              overflow_next = 1'b1;
            end else begin
              acc_next = mac[VALUE_W-1:0];
            end
            phase_next    = PH_DIGITS;
            accepted_next = taken_inc;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
    end
  end

  always_comb begin
    signed_val = neg ? (VALUE_W'(0) - acc) : acc;
    half       = VALUE_W'(1) << (tbits - 7'd1);
    lim        = half - VALUE_W'(1) + VALUE_W'(neg);
    res_ok     = base_ok && (accepted != '0) && !overflow;
    if (cfg.is_signed_type) begin
      if (acc > lim) begin
        res_ok = 1'b0;
      end
    end else if (tbits < 7'd64) begin
      if ((signed_val >> tbits) != '0) begin
        res_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      overflow  <= 1'b0;
      neg       <= 1'b0;
      phase     <= PH_START;
      taken     <= '0;
      accepted  <= '0;
      radix     <= RADIX_DEC;
      out_valid <= 1'b0;
    end else begin
      acc      <= acc_next;
      overflow <= overflow_next;
      neg      <= neg_next;
      phase    <= phase_next;
      taken    <= taken_next;
      accepted <= accepted_next;
      radix    <= radix_next;
      if (end_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (end_pop) begin
      number_value   <= res_ok ? signed_val : cfg.default_value;
      parse_ok       <= res_ok;
      consumed_count <= res_ok ? accepted : '0;
    end
  end

endmodule

[rtl/ascii_integer_parser.sv]
// Channel    Direction  Transaction carries
// s_axis     in         tdata: code_unit [20:0]; tlast: end_of_string
// m_axis     out        tdata: number_value [63:0], consumed_count [70:64]; tuser: parse_ok
// cfg        in         cfg_we, cfg_index, cfg_data (one register per write)
//
// One character is accepted per cycle while the queue is not full; the parser's
// multiply-by-radix and add is combinational, and a two-entry queue sits between
// classifier and parser. A result enters the output register at the edge at which
// the end item leaves the queue, into which every accepted item is first written.
// An output stall holds an end item at the head of the queue; items behind it wait,
// and the input stalls once two items are queued.
// Reset is synchronous and restores the register reset values and an empty string.
module ascii_integer_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // code_unit [20:0], zero padding
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // number_value [63:0], consumed_count [70:64], zero
  output logic        m_axis_tuser,   // parse_ok
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aip_pkg::*;

  cfg_t               cfg;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  char_item_t         q_in;
  char_item_t         q_head;
  logic [VALUE_W-1:0] number_value;
  logic [COUNT_W-1:0] consumed_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base     <= RADIX_DEC;
      cfg.value_size_code <= 2'd2;
      cfg.is_signed_type  <= 1'b1;
      cfg.default_value   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUMBER_BASE:     cfg.number_base     <= cfg_data[5:0];
        CFG_VALUE_SIZE_CODE: cfg.value_size_code <= cfg_data[1:0];
        CFG_IS_SIGNED_TYPE:  cfg.is_signed_type  <= cfg_data[0];
        CFG_DEFAULT_VALUE:   cfg.default_value   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  aip_front u_front (
    .tvalid    (s_axis_tvalid),
    .tready    (s_axis_tready),
    .code_unit (s_axis_tdata[CODE_W-1:0]),
    .tlast     (s_axis_tlast),
    .full      (q_full),
    .push      (q_push),
    .item      (q_in)
  );

  aip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  aip_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .empty          (q_empty),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .number_value   (number_value),
    .parse_ok       (m_axis_tuser),
    .consumed_count (consumed_count)
  );

  assign m_axis_tdata = {1'b0, consumed_count, number_value};

endmodule
